>>> rtl/core/integer_matrix_elementary_op_engine_unit_defines.svh
// Assertion helpers for the matrix engine checkers.
`ifndef INTEGER_MATRIX_ELEMENTARY_OP_ENGINE_UNIT_DEFINES_SVH
`define INTEGER_MATRIX_ELEMENTARY_OP_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IMEO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IMEO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/imeo_pkg.sv
// ----------------------------------------------------------------------------
// imeo_pkg
// Shared types and codes of the integer matrix elementary operation engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imeo_pkg;

  typedef enum logic [3:0] {
    OP_WRITE     = 4'd0,
    OP_READ      = 4'd1,
    OP_SWAP_COLS = 4'd2,
    OP_SWAP_ROWS = 4'd3,
    OP_SCALE_ROW = 4'd4,
    OP_SCALE_COL = 4'd5,
    OP_ADD_ROW   = 4'd6,
    OP_ADD_COL   = 4'd7,
    OP_MIN_PIVOT = 4'd8,
    OP_ROW_DIV   = 4'd9,
    OP_COL_DIV   = 4'd10,
    OP_REST_DIV  = 4'd11,
    OP_COUNTS    = 4'd12
  } op_e;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_INDEX = 2'd1;
  localparam logic [1:0] ERR_PIVOT = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam int BEST_W = 17;
  localparam logic [BEST_W-1:0] MIN_START = 17'd99999;

  typedef struct packed {
    logic [3:0]         op;
    logic [3:0]         index_a;
    logic [3:0]         index_b;
    logic signed [31:0] coeff;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic [3:0]         hit_row;
    logic [3:0]         hit_col;
    logic [4:0]         zero_cols;
    logic [4:0]         torsion_count;
    logic [1:0]         error;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_item_t;

endpackage

>>> rtl/core/imeo_ifs.sv
// ----------------------------------------------------------------------------
// imeo channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface imeo_in_if;
  logic               valid;
  logic               ready;
  imeo_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface imeo_out_if;
  logic                valid;
  logic                ready;
  imeo_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface imeo_cfg_if;
  logic                valid;
  logic                ready;
  imeo_pkg::cfg_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/imeo_ram.sv
// ----------------------------------------------------------------------------
// imeo_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imeo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/integer_matrix_elementary_op_engine_unit.sv
// ----------------------------------------------------------------------------
// integer_matrix_elementary_op_engine_unit
// Integer matrix store with elementary row/column operations and searches
// for Smith-normal-form reduction.
// ----------------------------------------------------------------------------
// Use: in_ch_i carries one operation item, out_ch_o returns exactly one
// result item per operation, cfg_ch_i writes rows_in_use / cols_in_use
// (always ready; write only while the engine is idle).
// One item is worked at a time; in_ch_i is ready only when the sequencer
// is idle. All element accesses go through a single RAM port pair, one
// shared 32x32 multiplier and one bit-serial divider.
// Swap/scale/add work element by element along the row or column; min pivot
// and counts scan the elements visited; divisibility searches run a
// bit-serial remainder test on each nonzero element visited.
// Reset: the matrix is zeroed by a clearing pass over all MAX_ROWS*MAX_COLS
// words, one word a cycle, during which no item is accepted.
// Stall: a finished result waits in the output register; a next item is
// accepted meanwhile, and its result holds until the old one is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_matrix_elementary_op_engine_unit #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  imeo_in_if.sink     in_ch_i,
  imeo_out_if.source  out_ch_o,
  imeo_cfg_if.sink    cfg_ch_i
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int LW0   = (NRW > NCW) ? NRW : NCW;
  localparam int LW    = (LW0 > 5) ? LW0 : 5;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_RDWAIT, S_RD1, S_RD2, S_CAP, S_MUL,
    S_WR1, S_WR2, S_PIV, S_SCAN_RD, S_SCAN_EV, S_DIV, S_OUT
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       clr_q;
  logic [4:0]          rows_q, cols_q;
  logic [3:0]          op_q;
  logic [LW-1:0]       a_q, b_q, r_q, c_q;
  logic [31:0]         k_q, wv_q, d1_q, d2_q, prod_q;
  logic [31:0]         den_q, rem_q, quo_q;
  logic [4:0]          step_q;
  logic [imeo_pkg::BEST_W-1:0] best_q;
  logic                phase_q;
  imeo_pkg::out_item_t res_q, out_q;
  logic                out_valid_q;

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] r, input logic [LW-1:0] c);
    addr_of = AW'(r[RW-1:0]) * AW'(MAX_COLS) + AW'(c[CW-1:0]);
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (32'd0 - v) : v;
  endfunction

  // effective sizes: zero acts as one, above the maximum clamps
  logic [LW-1:0] nr, nc, rows_ext, cols_ext;
  assign rows_ext = LW'(rows_q);
  assign cols_ext = LW'(cols_q);
  assign nr = (rows_q == 5'd0) ? LW'(1) : ((rows_ext > LW'(MAX_ROWS)) ? LW'(MAX_ROWS) : rows_ext);
  assign nc = (cols_q == 5'd0) ? LW'(1) : ((cols_ext > LW'(MAX_COLS)) ? LW'(MAX_COLS) : cols_ext);

  logic a_r_bad, a_c_bad, b_r_bad, b_c_bad;
  assign a_r_bad = (a_q >= nr);
  assign a_c_bad = (a_q >= nc);
  assign b_r_bad = (b_q >= nr);
  assign b_c_bad = (b_q >= nc);

  // line operation classes and element addresses (c_q is the line position)
  logic          is_swap, is_scale, is_colop;
  logic [AW-1:0] line_a1, line_a2;
  logic [LW-1:0] line_lim;
  always_comb begin
    is_swap  = 1'b0;
    is_scale = 1'b0;
    is_colop = 1'b0;
    line_a1  = addr_of(a_q, c_q);
    line_a2  = addr_of(a_q, c_q);
    case (imeo_pkg::op_e'(op_q))
      imeo_pkg::OP_SWAP_COLS: begin
        is_swap = 1'b1; is_colop = 1'b1;
        line_a1 = addr_of(c_q, a_q); line_a2 = addr_of(c_q, b_q);
      end
      imeo_pkg::OP_SWAP_ROWS: begin
        is_swap = 1'b1;
        line_a1 = addr_of(a_q, c_q); line_a2 = addr_of(b_q, c_q);
      end
      imeo_pkg::OP_SCALE_ROW: begin
        is_scale = 1'b1;
      end
      imeo_pkg::OP_SCALE_COL: begin
        is_scale = 1'b1; is_colop = 1'b1;
        line_a1 = addr_of(c_q, a_q); line_a2 = addr_of(c_q, a_q);
      end
      imeo_pkg::OP_ADD_ROW: begin
        line_a1 = addr_of(b_q, c_q); line_a2 = addr_of(a_q, c_q);
      end
      imeo_pkg::OP_ADD_COL: begin
        is_colop = 1'b1;
        line_a1 = addr_of(c_q, b_q); line_a2 = addr_of(c_q, a_q);
      end
      default: begin
      end
    endcase
    line_lim = is_colop ? nr : nc;
  end

  // scan cursor advance
  logic          adv_done;
  logic [LW-1:0] adv_r, adv_c, col0;
  always_comb begin
    col0     = (imeo_pkg::op_e'(op_q) == imeo_pkg::OP_MIN_PIVOT) ? a_q : (a_q + LW'(1));
    adv_done = 1'b0;
    adv_r    = r_q;
    adv_c    = c_q;
    case (imeo_pkg::op_e'(op_q))
      imeo_pkg::OP_ROW_DIV: begin
        if (c_q + LW'(1) < nc) adv_c = c_q + LW'(1);
        else adv_done = 1'b1;
      end
      imeo_pkg::OP_COL_DIV: begin
        if (r_q + LW'(1) < nr) adv_r = r_q + LW'(1);
        else adv_done = 1'b1;
      end
      default: begin
        if (c_q + LW'(1) < nc) begin
          adv_c = c_q + LW'(1);
        end else if (r_q + LW'(1) < nr) begin
          adv_r = r_q + LW'(1);
          adv_c = col0;
        end else begin
          adv_done = 1'b1;
        end
      end
    endcase
  end

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = addr_of(r_q, c_q);
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1; ram_waddr = clr_q;
      end
      S_DISP: begin
        if (imeo_pkg::op_e'(op_q) == imeo_pkg::OP_WRITE && !a_r_bad && !b_c_bad) begin
          ram_we = 1'b1; ram_waddr = addr_of(a_q, b_q); ram_wdata = wv_q;
        end
        if (imeo_pkg::op_e'(op_q) == imeo_pkg::OP_READ) ram_raddr = addr_of(a_q, b_q);
        else ram_raddr = addr_of(a_q, a_q);
      end
      S_RD1: ram_raddr = line_a1;
      S_RD2: ram_raddr = line_a2;
      S_WR1: begin
        ram_we = 1'b1;
        if (is_swap) begin
          ram_waddr = line_a1; ram_wdata = d2_q;
        end else if (is_scale) begin
          ram_waddr = line_a1; ram_wdata = prod_q;
        end else begin
          ram_waddr = line_a2; ram_wdata = d2_q + prod_q;
        end
      end
      S_WR2: begin
        ram_we = 1'b1; ram_waddr = line_a2; ram_wdata = d1_q;
      end
      default: begin
      end
    endcase
  end

  imeo_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_imeo_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // bit-serial remainder step
  logic [32:0] div_sh;
  logic [33:0] div_diff;
  logic [31:0] rem_nx;
  assign div_sh   = {rem_q, quo_q[31]};
  assign div_diff = {1'b0, div_sh} - {2'b00, den_q};
  assign rem_nx   = div_diff[33] ? div_sh[31:0] : div_diff[31:0];

  logic [31:0] mul_res;
  assign mul_res = k_q * d1_q;

  logic in_acc, out_acc, cfg_acc, out_load;
  assign in_ch_i.ready   = (state_q == S_IDLE);
  assign cfg_ch_i.ready  = 1'b1;
  assign in_acc          = in_ch_i.valid && in_ch_i.ready;
  assign out_acc         = out_ch_o.valid && out_ch_o.ready;
  assign cfg_acc         = cfg_ch_i.valid;
  assign out_load        = (state_q == S_OUT) && (!out_valid_q || out_ch_o.ready);
  assign out_ch_o.valid  = out_valid_q;
  assign out_ch_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rows_q      <= 5'd16;
      cols_q      <= 5'd16;
      op_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      wv_q        <= '0;
      d1_q        <= '0;
      d2_q        <= '0;
      prod_q      <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      best_q      <= '0;
      phase_q     <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        if (cfg_ch_i.payload.index == imeo_pkg::REG_ROWS) rows_q <= cfg_ch_i.payload.data[4:0];
        if (cfg_ch_i.payload.index == imeo_pkg::REG_COLS) cols_q <= cfg_ch_i.payload.data[4:0];
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            op_q    <= in_ch_i.payload.op;
            a_q     <= LW'(in_ch_i.payload.index_a);
            b_q     <= LW'(in_ch_i.payload.index_b);
            k_q     <= in_ch_i.payload.coeff;
            wv_q    <= in_ch_i.payload.write_value;
            res_q   <= '0;
            r_q     <= '0;
            c_q     <= '0;
            phase_q <= 1'b0;
            best_q  <= imeo_pkg::MIN_START;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          case (imeo_pkg::op_e'(op_q))
            imeo_pkg::OP_WRITE: begin
              if (a_r_bad || b_c_bad) res_q.error <= imeo_pkg::ERR_INDEX;
              state_q <= S_OUT;
            end
            imeo_pkg::OP_READ: begin
              if (a_r_bad || b_c_bad) begin
                res_q.error <= imeo_pkg::ERR_INDEX; state_q <= S_OUT;
              end else state_q <= S_RDWAIT;
            end
            imeo_pkg::OP_SWAP_COLS, imeo_pkg::OP_ADD_COL: begin
              if (a_c_bad || b_c_bad) begin
                res_q.error <= imeo_pkg::ERR_INDEX; state_q <= S_OUT;
              end else state_q <= S_RD1;
            end
            imeo_pkg::OP_SWAP_ROWS, imeo_pkg::OP_ADD_ROW: begin
              if (a_r_bad || b_r_bad) begin
                res_q.error <= imeo_pkg::ERR_INDEX; state_q <= S_OUT;
              end else state_q <= S_RD1;
            end
            imeo_pkg::OP_SCALE_ROW: begin
              if (a_r_bad) begin
                res_q.error <= imeo_pkg::ERR_INDEX; state_q <= S_OUT;
              end else state_q <= S_RD1;
            end
            imeo_pkg::OP_SCALE_COL: begin
              if (a_c_bad) begin
                res_q.error <= imeo_pkg::ERR_INDEX; state_q <= S_OUT;
              end else state_q <= S_RD1;
            end
            imeo_pkg::OP_MIN_PIVOT: begin
              // pivot outside the matrix finds nothing, no error
              if (!a_r_bad && !a_c_bad) begin
                r_q     <= a_q;
                c_q     <= a_q;
                state_q <= S_SCAN_RD;
              end else state_q <= S_OUT;
            end
            imeo_pkg::OP_ROW_DIV, imeo_pkg::OP_COL_DIV, imeo_pkg::OP_REST_DIV: begin
              if (a_r_bad || a_c_bad) begin
                res_q.error <= imeo_pkg::ERR_INDEX; state_q <= S_OUT;
              end else state_q <= S_PIV;
            end
            imeo_pkg::OP_COUNTS: state_q <= S_SCAN_RD;
            default: state_q <= S_OUT;
          endcase
        end
        S_RDWAIT: begin
          res_q.read_value <= rdata;
          state_q          <= S_OUT;
        end
        S_RD1: state_q <= S_RD2;
        S_RD2: begin
          d1_q    <= rdata;
          state_q <= S_CAP;
        end
        S_CAP: begin
          d2_q    <= rdata;
          state_q <= is_swap ? S_WR1 : S_MUL;
        end
        S_MUL: begin
          prod_q  <= mul_res;
          state_q <= S_WR1;
        end
        S_WR1, S_WR2: begin
          if (state_q == S_WR1 && is_swap) begin
            state_q <= S_WR2;
          end else if (c_q + LW'(1) == line_lim) begin
            state_q <= S_OUT;
          end else begin
            c_q     <= c_q + LW'(1);
            state_q <= S_RD1;
          end
        end
        S_PIV: begin
          if (rdata == 32'd0) begin
            res_q.error <= imeo_pkg::ERR_PIVOT;
            state_q     <= S_OUT;
          end else begin
            den_q <= mag(rdata);
            if (imeo_pkg::op_e'(op_q) == imeo_pkg::OP_REST_DIV) begin
              r_q <= a_q + LW'(1);
              c_q <= a_q + LW'(1);
              if (a_q + LW'(1) >= nr || a_q + LW'(1) >= nc) state_q <= S_OUT;
              else state_q <= S_SCAN_RD;
            end else begin
              r_q     <= a_q;
              c_q     <= a_q;
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_EV;
        S_SCAN_EV: begin
          case (imeo_pkg::op_e'(op_q))
            imeo_pkg::OP_MIN_PIVOT: begin
              if (rdata != 32'd0 && mag(rdata) < 32'(best_q)) begin
                best_q        <= imeo_pkg::BEST_W'(mag(rdata));
                res_q.found   <= 1'b1;
                res_q.hit_row <= r_q[3:0];
                res_q.hit_col <= c_q[3:0];
              end
              r_q     <= adv_r;
              c_q     <= adv_c;
              state_q <= adv_done ? S_OUT : S_SCAN_RD;
            end
            imeo_pkg::OP_COUNTS: begin
              if (!phase_q && rdata == 32'd0) begin
                res_q.zero_cols <= res_q.zero_cols + 5'd1;
                c_q             <= c_q + LW'(1);
                state_q         <= (c_q + LW'(1) == nc) ? S_OUT : S_SCAN_RD;
              end else begin
                // diagonal shifted by the leading zero count
                phase_q <= 1'b1;
                if (!rdata[31] && rdata > 32'd1) begin
                  res_q.torsion_count <= res_q.torsion_count + 5'd1;
                  r_q     <= r_q + LW'(1);
                  c_q     <= c_q + LW'(1);
                  state_q <= (c_q + LW'(1) == nc || r_q + LW'(1) == nr) ? S_OUT : S_SCAN_RD;
                end else begin
                  state_q <= S_OUT;
                end
              end
            end
            default: begin
              if (rdata != 32'd0) begin
                rem_q   <= '0;
                quo_q   <= mag(rdata);
                step_q  <= '0;
                state_q <= S_DIV;
              end else begin
                r_q     <= adv_r;
                c_q     <= adv_c;
                state_q <= adv_done ? S_OUT : S_SCAN_RD;
              end
            end
          endcase
        end
        S_DIV: begin
          rem_q  <= rem_nx;
          quo_q  <= {quo_q[30:0], 1'b0};
          step_q <= step_q + 5'd1;
          if (step_q == 5'd31) begin
            if (rem_nx != 32'd0) begin
              res_q.found   <= 1'b1;
              res_q.hit_row <= r_q[3:0];
              res_q.hit_col <= c_q[3:0];
            end
            r_q     <= adv_r;
            c_q     <= adv_c;
            state_q <= adv_done ? S_OUT : S_SCAN_RD;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/imeo_checker.sv
// ----------------------------------------------------------------------------
// imeo_sva_checker
// Port-level checks on the result channel of the matrix engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_matrix_elementary_op_engine_unit_defines.svh"

module imeo_sva_checker (
  input logic        clk_i,
  input logic        rst_ni,
  imeo_out_if.source out_ch
);

  `IMEO_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.payload), "result item changed while stalled")

  `IMEO_ASSERT_IMP(a_hit_zero, clk_i, rst_ni, out_ch.valid && !out_ch.payload.found, out_ch.payload.hit_row == 4'd0 && out_ch.payload.hit_col == 4'd0, "hit position set without a find")

  `IMEO_ASSERT_IMP(a_err_clean, clk_i, rst_ni, out_ch.valid && out_ch.payload.error != imeo_pkg::ERR_OK, !out_ch.payload.found && out_ch.payload.read_value == 32'sd0 && out_ch.payload.zero_cols == 5'd0 && out_ch.payload.torsion_count == 5'd0, "error item carries data")

endmodule

bind integer_matrix_elementary_op_engine_unit imeo_sva_checker u_imeo_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .out_ch (out_ch_o)
);

>>> test/imeo_checker.sv
// ----------------------------------------------------------------------------
// imeo_checker
// Watches the item, result and register channels of the matrix engine,
// keeps its own copy of the matrix and registers, predicts each result item
// and compares it field by field with what the engine returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imeo_checker
  import imeo_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  imeo_in_if   in_ch,
  imeo_out_if  out_ch,
  imeo_cfg_if  cfg_ch,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int NROW = 16;
  localparam int NCOL = 16;

  logic [31:0] mat_q [NROW][NCOL];
  logic [4:0]  rows_q;
  logic [4:0]  cols_q;
  out_item_t   result_fifo[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = result_fifo.size();

  function automatic int clamp_dim(logic [4:0] v, int lim);
    if (v == 5'd0) return 1;
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic logic [32:0] magnitude(logic [31:0] v);
    return v[31] ? {1'b0, -v} : {1'b0, v};
  endfunction

  // nonzero and not a multiple of a nonzero pivot
  function automatic logic misfit(logic [31:0] v, logic [31:0] piv);
    longint a, b;
    a = longint'($signed(v));
    b = longint'($signed(piv));
    if (a == 0) return 1'b0;
    return (a % b) != 0;
  endfunction

  task automatic apply_op(input in_item_t it, output out_item_t res);
    int nr, nc, a, b, r, c, row, zc;
    logic [31:0] t, k, piv;
    logic [32:0] best;
    logic stop;
    nr = clamp_dim(rows_q, NROW);
    nc = clamp_dim(cols_q, NCOL);
    a = int'(it.index_a);
    b = int'(it.index_b);
    k = it.coeff;
    res = '0;
    case (it.op)
      OP_WRITE, OP_READ: begin
        if (a >= nr || b >= nc) res.error = ERR_INDEX;
        else if (it.op == OP_WRITE) mat_q[a][b] = it.write_value;
        else res.read_value = mat_q[a][b];
      end
      OP_SWAP_COLS: begin
        if (a >= nc || b >= nc) res.error = ERR_INDEX;
        else for (r = 0; r < nr; r++) begin
          t = mat_q[r][a]; mat_q[r][a] = mat_q[r][b]; mat_q[r][b] = t;
        end
      end
      OP_SWAP_ROWS: begin
        if (a >= nr || b >= nr) res.error = ERR_INDEX;
        else for (c = 0; c < nc; c++) begin
          t = mat_q[a][c]; mat_q[a][c] = mat_q[b][c]; mat_q[b][c] = t;
        end
      end
      OP_SCALE_ROW: begin
        if (a >= nr) res.error = ERR_INDEX;
        else for (c = 0; c < nc; c++) mat_q[a][c] = mat_q[a][c] * k;
      end
      OP_SCALE_COL: begin
        if (a >= nc) res.error = ERR_INDEX;
        else for (r = 0; r < nr; r++) mat_q[r][a] = mat_q[r][a] * k;
      end
      OP_ADD_ROW: begin
        if (a >= nr || b >= nr) res.error = ERR_INDEX;
        else for (c = 0; c < nc; c++) mat_q[a][c] = mat_q[a][c] + k * mat_q[b][c];
      end
      OP_ADD_COL: begin
        if (a >= nc || b >= nc) res.error = ERR_INDEX;
        else for (r = 0; r < nr; r++) mat_q[r][a] = mat_q[r][a] + k * mat_q[r][b];
      end
      OP_MIN_PIVOT: begin
        best = 33'd99999;
        for (r = a; r < nr; r++)
          for (c = a; c < nc; c++)
            if (mat_q[r][c] != 0 && magnitude(mat_q[r][c]) < best) begin
              best = magnitude(mat_q[r][c]);
              res.found = 1'b1; res.hit_row = 4'(r); res.hit_col = 4'(c);
            end
      end
      OP_ROW_DIV, OP_COL_DIV, OP_REST_DIV: begin
        if (a >= nr || a >= nc) res.error = ERR_INDEX;
        else if (mat_q[a][a] == 0) res.error = ERR_PIVOT;
        else begin
          piv = mat_q[a][a];
          if (it.op == OP_ROW_DIV) begin
            for (c = a; c < nc; c++)
              if (misfit(mat_q[a][c], piv)) begin
                res.found = 1'b1; res.hit_row = 4'(a); res.hit_col = 4'(c);
              end
          end else if (it.op == OP_COL_DIV) begin
            for (r = a; r < nr; r++)
              if (misfit(mat_q[r][a], piv)) begin
                res.found = 1'b1; res.hit_row = 4'(r); res.hit_col = 4'(a);
              end
          end else begin
            for (r = a + 1; r < nr; r++)
              for (c = a + 1; c < nc; c++)
                if (misfit(mat_q[r][c], piv)) begin
                  res.found = 1'b1; res.hit_row = 4'(r); res.hit_col = 4'(c);
                end
          end
        end
      end
      OP_COUNTS: begin
        c = 0;
        while (c < nc && mat_q[0][c] == 0) c++;
        zc = c;
        res.zero_cols = 5'(zc);
        stop = 1'b0;
        for (c = zc; c < nc && !stop; c++) begin
          row = c - zc;
          if (row >= nr || $signed(mat_q[row][c]) <= 1) stop = 1'b1;
          else res.torsion_count = res.torsion_count + 5'd1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item, got;
    if (!rst_ni) begin
      for (int r = 0; r < NROW; r++)
        for (int c = 0; c < NCOL; c++) mat_q[r][c] = '0;
      rows_q = 5'd16;
      cols_q = 5'd16;
      result_fifo.delete();
      fails = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.payload.index == REG_ROWS) rows_q = cfg_ch.payload.data[4:0];
        else if (cfg_ch.payload.index == REG_COLS) cols_q = cfg_ch.payload.data[4:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (result_fifo.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result item %p", got);
        end else begin
          exp_item = result_fifo.pop_front();
          if (got.read_value !== exp_item.read_value || got.found !== exp_item.found ||
              got.hit_row !== exp_item.hit_row || got.hit_col !== exp_item.hit_col ||
              got.zero_cols !== exp_item.zero_cols ||
              got.torsion_count !== exp_item.torsion_count ||
              got.error !== exp_item.error) begin
            fails++;
            if (fails <= 10)
              $display("mismatch at %0t: expected %p actual %p", $realtime, exp_item, got);
          end
        end
      end
      // input after result: a result can never belong to an item taken this edge
      if (in_ch.valid && in_ch.ready) begin
        apply_op(in_ch.payload, exp_item);
        result_fifo.push_back(exp_item);
      end
    end
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random operation items and register writes into the
// matrix engine under varying idle patterns; a checker beside the engine
// predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import imeo_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  int   send_idle, recv_idle;
  logic in_acc_q, cfg_acc_q;

  imeo_in_if  in_ch ();
  imeo_out_if out_ch ();
  imeo_cfg_if cfg_ch ();

  integer_matrix_elementary_op_engine_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch),
    .cfg_ch_i(cfg_ch)
  );

  imeo_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    in_acc_q  <= in_ch.valid && in_ch.ready;
    cfg_acc_q <= cfg_ch.valid && cfg_ch.ready;
  end

  always @(negedge clk_i) out_ch.ready <= ($urandom_range(99) >= recv_idle);

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom();
      3:       return 32'(-1);
      default: return 32'($signed($urandom_range(10)) - 5);
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next item may follow without a gap
  task automatic send_item(input logic [3:0] op, input logic [3:0] a, input logic [3:0] b,
                           input logic [31:0] k, input logic [31:0] wv);
    in_item_t it;
    it.op = op; it.index_a = a; it.index_b = b; it.coeff = k; it.write_value = wv;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(negedge clk_i); while (!in_acc_q);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: data};
    do @(negedge clk_i); while (!cfg_acc_q);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_item(input int nr, input int nc);
    logic [3:0] op, a, b;
    int lim;
    lim = (nr < nc ? nr : nc);
    if ($urandom_range(99) < 40) op = OP_WRITE;
    else op = 4'($urandom_range(15));
    a = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(lim - 1));
    b = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
        4'($urandom_range(((op == OP_WRITE || op == OP_READ) ? nc : lim) - 1));
    if (op == OP_WRITE && $urandom_range(9) == 0) a = 4'($urandom_range(nr - 1));
    send_item(op, a, b, rand_value(), rand_value());
  endtask

  initial begin
    int dims_r[6] = '{2, 5, 16, 0, 4, 3};
    int dims_c[6] = '{3, 4, 16, 1, 20, 6};
    int nr, nc;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    send_idle = 9;
    recv_idle = 59;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part on the full 16x16 matrix
    send_item(OP_COUNTS, 0, 0, 0, 0);                 // all zero at reset
    send_item(OP_WRITE, 0, 0, 0, 32'h8000_0000);
    send_item(OP_WRITE, 15, 15, 0, 32'h7fff_ffff);
    send_item(OP_WRITE, 1, 1, 0, 32'd6);
    send_item(OP_WRITE, 1, 3, 0, 32'd4);
    send_item(OP_WRITE, 3, 1, 0, 32'(-9));
    send_item(OP_READ, 15, 15, 0, 0);
    send_item(OP_MIN_PIVOT, 0, 0, 0, 0);
    send_item(OP_MIN_PIVOT, 15, 0, 0, 0);
    send_item(OP_ROW_DIV, 1, 0, 0, 0);
    send_item(OP_COL_DIV, 1, 0, 0, 0);
    send_item(OP_REST_DIV, 0, 0, 32'(-1), 0);
    send_item(OP_ROW_DIV, 2, 0, 0, 0);                // zero pivot
    send_item(OP_SWAP_COLS, 0, 15, 0, 0);
    send_item(OP_SWAP_ROWS, 1, 3, 0, 0);
    send_item(OP_SCALE_ROW, 1, 0, 32'(-1), 0);
    send_item(OP_SCALE_COL, 3, 0, 32'h8000_0000, 0);
    send_item(OP_ADD_ROW, 3, 3, 32'd2, 0);            // same row as source
    send_item(OP_ADD_COL, 1, 15, 32'h7fff_ffff, 0);
    send_item(OP_COUNTS, 0, 0, 0, 0);
    send_item(4'd13, 15, 15, 32'hffff_ffff, 32'hffff_ffff);
    write_reg(REG_ROWS, 32'd2);
    write_reg(REG_COLS, 32'd0);                       // acts as one column
    send_item(OP_READ, 2, 0, 0, 0);                   // bad row
    send_item(OP_REST_DIV, 1, 1, 0, 0);               // pivot outside
    send_item(OP_COUNTS, 0, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 59; recv_idle = 9; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      write_reg(REG_ROWS, {$urandom() & 32'hffff_ffe0} | 32'(dims_r[ph]));
      write_reg(REG_COLS, {$urandom() & 32'hffff_ffe0} | 32'(dims_c[ph]));
      nr = dims_r[ph] == 0 ? 1 : (dims_r[ph] > 16 ? 16 : dims_r[ph]);
      nc = dims_c[ph] == 0 ? 1 : (dims_c[ph] > 16 ? 16 : dims_c[ph]);
      for (int i = 0; i < 80; i++) random_item(nr, nc);
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/imeo_pkg.sv
rtl/core/imeo_ifs.sv
rtl/core/imeo_ram.sv
rtl/core/integer_matrix_elementary_op_engine_unit.sv
rtl/core/imeo_checker.sv
test/imeo_checker.sv
test/testbench.sv
